FILE: src/csvt_pkg.sv
// ----------------------------------------------------------------------------
// csvt_pkg
// Shared types and codes of the CSV field tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package csvt_pkg;

  localparam logic [7:0] QUOTE_CHAR      = 8'h22;
  localparam logic [7:0] NEWLINE_CHAR    = 8'h0A;
  localparam logic [7:0] SEPARATOR_RESET = 8'h2C;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [2:0] KIND_CONTENT   = 3'd0;
  localparam logic [2:0] KIND_FIELD_END = 3'd1;
  localparam logic [2:0] KIND_ROW_END   = 3'd2;
  localparam logic [2:0] KIND_DONE      = 3'd3;
  localparam logic [2:0] KIND_ERROR     = 3'd4;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_QUOTE  = 3'd1;
  localparam logic [2:0] ERR_COLUMNS    = 3'd2;
  localparam logic [2:0] ERR_TOO_LONG   = 3'd3;
  localparam logic [2:0] ERR_OPEN_QUOTE = 3'd4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  content_byte;
    logic [7:0]  column_index;
    logic [31:0] row_index;
    logic [2:0]  fault_code;
    logic        closed_partial_row;
  } result_t;

endpackage

`default_nettype wire

FILE: src/csvt_in_stage.sv
// ----------------------------------------------------------------------------
// csvt_in_stage
// Input register: holds one item until the parser takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_in_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire csvt_pkg::item_t in_item,
  input  wire logic            take,
  output logic                 held_valid,
  output csvt_pkg::item_t      held_item
);

  assign in_stall = held_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (!in_stall) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_item <= in_item;
    end
  end

endmodule

`default_nettype wire

FILE: src/csvt_parser.sv
// ----------------------------------------------------------------------------
// csvt_parser
// Tokenizer state and the one-item step: mode, column and token counters,
// row count and the separator register.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_parser #(
  parameter int MAX_TOKEN_BYTES = 65536,
  parameter int MAX_COLUMNS     = 255
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_wr_en,
  input  wire logic [7:0]      cfg_wr_data,
  input  wire logic            step,
  input  wire csvt_pkg::item_t item,
  output logic                 res_valid,
  output csvt_pkg::result_t    res
);

  localparam int CW = $clog2(MAX_COLUMNS + 1);
  localparam int TW = $clog2(MAX_TOKEN_BYTES + 1);
  localparam logic [CW-1:0] COL_LIMIT = CW'(MAX_COLUMNS);
  localparam logic [TW-1:0] TOK_LIMIT = TW'(MAX_TOKEN_BYTES);

  typedef enum logic [2:0] {
    M_START, M_PLAIN, M_QUOTED, M_CLOSED, M_ERROR, M_DONE
  } mode_t;

  mode_t       mode, mode_next;
  logic [7:0]  separator;
  logic [CW-1:0] column_count, column_count_next;
  logic [CW-1:0] expected_columns, expected_columns_next;
  logic        first_row_pending, first_row_pending_next;
  logic [TW-1:0] token_length, token_length_next;
  logic [31:0] row_count, row_count_next;
  logic        row_has_data, row_has_data_next;

  logic [CW:0]   col_inc;
  logic [CW-1:0] limit;
  logic          field_ok;
  logic          row_ok;
  logic          is_sep;
  logic          is_nl;
  logic          is_quote;
  logic [7:0]    col8;

  assign col_inc  = {1'b0, column_count} + 1'b1;
  assign limit    = first_row_pending ? COL_LIMIT : expected_columns;
  assign field_ok = col_inc < {1'b0, limit};
  assign row_ok   = first_row_pending || (col_inc == {1'b0, expected_columns});
  assign is_sep   = item.data_byte == separator;
  assign is_nl    = item.data_byte == csvt_pkg::NEWLINE_CHAR;
  assign is_quote = item.data_byte == csvt_pkg::QUOTE_CHAR;
  assign col8     = 8'(column_count);

  always_comb begin
    mode_next              = mode;
    column_count_next      = column_count;
    expected_columns_next  = expected_columns;
    first_row_pending_next = first_row_pending;
    token_length_next      = token_length;
    row_count_next         = row_count;
    row_has_data_next      = row_has_data;
    res_valid              = 1'b0;
    res.kind               = csvt_pkg::KIND_ERROR;
    res.content_byte       = 8'd0;
    res.column_index       = col8;
    res.row_index          = row_count;
    res.fault_code         = csvt_pkg::ERR_NONE;
    res.closed_partial_row = 1'b0;

    if (mode != M_ERROR && mode != M_DONE) begin
      if (item.op == csvt_pkg::OP_END) begin
        res_valid = 1'b1;
        if (mode == M_QUOTED) begin
          mode_next      = M_ERROR;
          res.fault_code = csvt_pkg::ERR_OPEN_QUOTE;
        end else if (row_has_data && !row_ok) begin
          mode_next      = M_ERROR;
          res.fault_code = csvt_pkg::ERR_COLUMNS;
        end else begin
          mode_next              = M_DONE;
          res.kind               = csvt_pkg::KIND_DONE;
          res.column_index       = 8'd0;
          res.closed_partial_row = row_has_data;
          if (row_has_data) begin
            if (first_row_pending) begin
              expected_columns_next = col_inc[CW-1:0];
            end
            first_row_pending_next = 1'b0;
            row_count_next         = row_count + 32'd1;
            res.row_index          = row_count + 32'd1;
            column_count_next      = '0;
            token_length_next      = '0;
            row_has_data_next      = 1'b0;
          end
        end
      end else begin
        row_has_data_next = 1'b1;
        if (mode == M_START && is_quote) begin
          mode_next         = M_QUOTED;
          token_length_next = '0;
        end else if (mode == M_QUOTED) begin
          if (is_quote) begin
            mode_next = M_CLOSED;
          end else begin
            res_valid = 1'b1;
            if (token_length >= TOK_LIMIT) begin
              mode_next      = M_ERROR;
              res.fault_code = csvt_pkg::ERR_TOO_LONG;
            end else begin
              token_length_next = token_length + 1'b1;
              res.kind          = csvt_pkg::KIND_CONTENT;
              res.content_byte  = item.data_byte;
            end
          end
        end else if (is_sep) begin
          res_valid = 1'b1;
          if (!field_ok) begin
            mode_next      = M_ERROR;
            res.fault_code = csvt_pkg::ERR_COLUMNS;
          end else begin
            mode_next         = M_START;
            column_count_next = col_inc[CW-1:0];
            token_length_next = '0;
            res.kind          = csvt_pkg::KIND_FIELD_END;
          end
        end else if (is_nl) begin
          res_valid = 1'b1;
          if (!row_ok) begin
            mode_next      = M_ERROR;
            res.fault_code = csvt_pkg::ERR_COLUMNS;
          end else begin
            if (first_row_pending) begin
              expected_columns_next = col_inc[CW-1:0];
            end
            first_row_pending_next = 1'b0;
            row_count_next         = row_count + 32'd1;
            column_count_next      = '0;
            token_length_next      = '0;
            row_has_data_next      = 1'b0;
            mode_next              = M_START;
            res.kind               = csvt_pkg::KIND_ROW_END;
          end
        end else if (mode == M_CLOSED) begin
          res_valid      = 1'b1;
          mode_next      = M_ERROR;
          res.fault_code = csvt_pkg::ERR_BAD_QUOTE;
        end else begin
          // plain content; a field start restarts the length count
          res_valid = 1'b1;
          if (mode == M_PLAIN && token_length >= TOK_LIMIT) begin
            mode_next      = M_ERROR;
            res.fault_code = csvt_pkg::ERR_TOO_LONG;
          end else begin
            mode_next         = M_PLAIN;
            token_length_next = (mode == M_START) ? TW'(1) : token_length + 1'b1;
            res.kind          = csvt_pkg::KIND_CONTENT;
            res.content_byte  = item.data_byte;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode              <= M_START;
      separator         <= csvt_pkg::SEPARATOR_RESET;
      column_count      <= '0;
      expected_columns  <= '0;
      first_row_pending <= 1'b1;
      token_length      <= '0;
      row_count         <= '0;
      row_has_data      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        separator <= cfg_wr_data;
      end
      if (step) begin
        mode              <= mode_next;
        column_count      <= column_count_next;
        expected_columns  <= expected_columns_next;
        first_row_pending <= first_row_pending_next;
        token_length      <= token_length_next;
        row_count         <= row_count_next;
        row_has_data      <= row_has_data_next;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/csvt_out_stage.sv
// ----------------------------------------------------------------------------
// csvt_out_stage
// Result register towards the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_out_stage (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load,
  input  wire csvt_pkg::result_t res,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output csvt_pkg::result_t      out_res,
  output logic                   has_room
);

  assign has_room = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (has_room) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && has_room) begin
      out_res <= res;
    end
  end

endmodule

`default_nettype wire

FILE: src/csv_field_tokenizer_core.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_core
// Streaming CSV tokenizer: splits bytes into content, field and row events,
// checks quoting, token length and column count.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  in       | in_valid / in_stall  | op, data_byte
//  out      | out_valid / out_stall| kind, content_byte, column_index,
//           |                      | row_index, fault_code, closed_partial_row
//  config   | cfg_wr_en            | cfg_wr_data (separator)
//
// One item per cycle sustained unless the output stalls; path: input register,
// then result register. The step itself is one pass of the parser logic.
// Synchronous reset clears state and restores the separator to a comma.
// A stalled output holds the input register; an item that yields no result
// still moves through only when the result register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module csv_field_tokenizer_core #(
  parameter int MAX_TOKEN_BYTES = 65536,
  parameter int MAX_COLUMNS     = 255
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        op,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       kind,
  output logic [7:0]       content_byte,
  output logic [7:0]       column_index,
  output logic [31:0]      row_index,
  output logic [2:0]       fault_code,
  output logic             closed_partial_row
);

  csvt_pkg::item_t   in_item;
  csvt_pkg::item_t   held_item;
  csvt_pkg::result_t res;
  csvt_pkg::result_t out_res;
  logic              held_valid;
  logic              has_room;
  logic              take;
  logic              res_valid;

  assign in_item.op        = op;
  assign in_item.data_byte = data_byte;
  assign take              = held_valid && has_room;

  csvt_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .take       (take),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  csvt_parser #(
    .MAX_TOKEN_BYTES (MAX_TOKEN_BYTES),
    .MAX_COLUMNS     (MAX_COLUMNS)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (take),
    .item        (held_item),
    .res_valid   (res_valid),
    .res         (res)
  );

  csvt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (take && res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res),
    .has_room  (has_room)
  );

  assign kind               = out_res.kind;
  assign content_byte       = out_res.content_byte;
  assign column_index       = out_res.column_index;
  assign row_index          = out_res.row_index;
  assign fault_code         = out_res.fault_code;
  assign closed_partial_row = out_res.closed_partial_row;

endmodule

`default_nettype wire

FILE: src/csvt_checker.sv
// ----------------------------------------------------------------------------
// csvt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module csvt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [2:0]  kind,
  input wire logic [7:0]  content_byte,
  input wire logic [7:0]  column_index,
  input wire logic [2:0]  fault_code,
  input wire logic        closed_partial_row
);

  logic finished;

  always_ff @(posedge clk) begin
    if (rst) begin
      finished <= 1'b0;
    end else if (out_valid && !out_stall &&
                 (kind == csvt_pkg::KIND_DONE || kind == csvt_pkg::KIND_ERROR)) begin
      finished <= 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(content_byte))
    else $error("stalled item changed");

  a_nothing_after_end: assert property (@(posedge clk) disable iff (rst)
    finished |-> !out_valid)
    else $error("item after stream done or error");

  a_error_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((kind == csvt_pkg::KIND_ERROR) == (fault_code != csvt_pkg::ERR_NONE)))
    else $error("error code does not match kind");

  a_done_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != csvt_pkg::KIND_DONE |-> !closed_partial_row)
    else $error("partial-row flag outside stream done");

  a_done_column: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == csvt_pkg::KIND_DONE |-> column_index == 8'd0 && content_byte == 8'd0)
    else $error("stream done carries column or byte");

endmodule

bind csv_field_tokenizer_core csvt_checker u_csvt_checker (
  .clk                (clk),
  .rst                (rst),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .kind               (kind),
  .content_byte       (content_byte),
  .column_index       (column_index),
  .fault_code         (fault_code),
  .closed_partial_row (closed_partial_row)
);

`default_nettype wire
